// ===== hw/rtl/hlt_pkg.sv =====
package hlt_pkg;

	localparam int HLT_NODE_SLOTS = 16;

	localparam int CFG_W = 31;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSPECT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE = 1'b1;
	localparam logic [CFG_W-1:0] SUSPECT_RESET = 31'd15000;
	localparam logic [CFG_W-1:0] OFFLINE_RESET = 31'd30000;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_START = 4'd1;
	localparam logic [3:0] OP_STOP = 4'd2;
	localparam logic [3:0] OP_TICK = 4'd3;
	localparam logic [3:0] OP_HANDSHAKE = 4'd4;
	localparam logic [3:0] OP_HEARTBEAT = 4'd5;
	localparam logic [3:0] OP_DOWN = 4'd6;
	localparam logic [3:0] OP_QUERY = 4'd7;
	localparam logic [3:0] OP_ROUTES = 4'd8;

	localparam logic [2:0] ST_CONNECTING = 3'd0;
	localparam logic [2:0] ST_ONLINE = 3'd1;
	localparam logic [2:0] ST_SUSPECT = 3'd2;
	localparam logic [2:0] ST_OFFLINE = 3'd3;
	localparam logic [2:0] ST_REMOVED = 3'd4;

	localparam logic [2:0] REACH_OK = 3'd0;
	localparam logic [2:0] REACH_NOT_FOUND = 3'd1;
	localparam logic [2:0] REACH_SUSPECT = 3'd2;
	localparam logic [2:0] REACH_OFFLINE = 3'd3;
	localparam logic [2:0] REACH_REMOVED = 3'd4;

	typedef struct packed {
		logic [3:0] operation;
		logic [3:0] node_slot;
		logic [63:0] peer_epoch;
		logic [31:0] time_now;
	} request_t;

	typedef struct packed {
		logic node_known;
		logic [2:0] node_state_out;
		logic [2:0] reach_status;
		logic [4:0] change_count;
		logic routes_flush;
		logic routes_accepted;
	} result_t;

	typedef struct packed {
		logic [2:0] state;
		logic [31:0] connect_time;
		logic [31:0] heartbeat_time;
		logic [63:0] slot_epoch;
	} slot_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_UPDATE,
		S_SWEEP,
		S_FETCH,
		S_REPORT
	} ctl_state_t;

	typedef struct packed {
		logic latch;
		logic update;
		logic sweep;
		logic report;
	} ctl_cmd_t;

	typedef struct packed {
		logic sweep_req;
		logic sweep_done;
		logic out_free;
	} dp_status_t;

	function automatic logic [2:0] reach_of(input logic known, input logic [2:0] st);
		logic [2:0] r;
		if (!known) begin
			r = REACH_NOT_FOUND;
		end else begin
			case (st) inside
				ST_CONNECTING, ST_ONLINE: r = REACH_OK;
				ST_SUSPECT: r = REACH_SUSPECT;
				ST_REMOVED: r = REACH_REMOVED;
				default: r = REACH_OFFLINE;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hlt_stream_if.sv =====
interface hlt_stream_if #(parameter type word_t = logic);
	logic valid;
	logic ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/hlt_ram.sv =====
module hlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/hlt_ctrl.sv =====
module hlt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hlt_pkg::dp_status_t status,
	output hlt_pkg::ctl_cmd_t cmd
);
	import hlt_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = status.sweep_req ? S_SWEEP : S_READ;
				end
			end
			S_READ: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d = S_FETCH;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_done) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_REPORT;
			end
			S_REPORT: begin
				if (status.out_free) begin
					cmd.report = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== hw/rtl/hlt_dp.sv =====
module hlt_dp #(
	parameter int NODE_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [hlt_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hlt_pkg::CFG_W-1:0] cfg_data,
	input hlt_pkg::request_t req_data,
	input hlt_pkg::ctl_cmd_t cmd,
	output hlt_pkg::dp_status_t status,
	output logic out_valid,
	output hlt_pkg::result_t out_data,
	input logic out_ready
);
	import hlt_pkg::*;

	localparam int ADDR_W = NODE_SLOTS > 1 ? $clog2(NODE_SLOTS) : 1;
	localparam int CNT_W = $clog2(NODE_SLOTS + 1);
	localparam int WORD_W = $bits(slot_word_t);

	logic [3:0] op_q;
	logic [3:0] slot_q;
	logic [63:0] epoch_q;
	logic [31:0] time_q;

	logic [CFG_W-1:0] suspect_q;
	logic [CFG_W-1:0] offline_q;
	logic running_q;
	logic [NODE_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic proc_s1;
	logic [ADDR_W-1:0] proc_idx_s1;
	logic [4:0] change_q;
	logic flush_q;
	logic accepted_q;
	logic out_valid_q;
	result_t out_data_q;

	logic [ADDR_W+3:0] slot_ext;
	logic [ADDR_W-1:0] slot_addr;
	logic in_table;
	logic known;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	slot_word_t rd_word;

	logic [31:0] stamp;
	logic [CFG_W-1:0] limit;
	logic [31:0] elapsed;
	logic fire;
	logic proc_valid;
	logic [2:0] tick_state;
	logic tick_change;
	logic sweep_we;
	slot_word_t sweep_word;
	logic sweep_active;

	slot_word_t upd_word;
	logic upd_we;
	logic upd_flush;
	logic upd_accept;
	logic upd_start;
	result_t result;

	assign slot_ext = (ADDR_W + 4)'(slot_q);
	assign slot_addr = slot_ext[ADDR_W-1:0];
	assign in_table = slot_ext < (ADDR_W + 4)'(NODE_SLOTS);
	assign known = in_table && valid_q[slot_addr];
	assign rd_word = slot_word_t'(ram_rdata);

	assign sweep_active = rd_cnt_q < CNT_W'(NODE_SLOTS);

	// One subtract and compare serves all three timeouts of a slot.
	always_comb begin
		stamp = (rd_word.state == ST_CONNECTING) ? rd_word.connect_time : rd_word.heartbeat_time;
		limit = (rd_word.state == ST_ONLINE) ? suspect_q : offline_q;
		elapsed = time_q - stamp;
		fire = !elapsed[31] && (elapsed > {1'b0, limit});
		proc_valid = valid_q[proc_idx_s1];
		tick_state = rd_word.state;
		case (rd_word.state)
			ST_CONNECTING: tick_state = fire ? ST_OFFLINE : ST_CONNECTING;
			ST_ONLINE: tick_state = fire ? ST_SUSPECT : ST_ONLINE;
			ST_SUSPECT: tick_state = fire ? ST_OFFLINE : ST_SUSPECT;
			default: tick_state = rd_word.state;
		endcase
		tick_change = (op_q == OP_TICK) && proc_valid && (tick_state != rd_word.state);
		sweep_we = cmd.sweep && proc_s1 && proc_valid && ((op_q == OP_STOP) || tick_change);
		sweep_word = rd_word;
		sweep_word.state = (op_q == OP_STOP) ? ST_REMOVED : tick_state;
	end

	always_comb begin
		upd_word = rd_word;
		upd_we = 1'b0;
		upd_flush = 1'b0;
		upd_accept = 1'b0;
		upd_start = 1'b0;
		case (op_q)
			OP_ADD: begin
				upd_we = in_table;
				upd_word.state = ST_CONNECTING;
				upd_word.connect_time = time_q;
				upd_word.heartbeat_time = '0;
				upd_word.slot_epoch = '0;
			end
			OP_START: begin
				upd_start = 1'b1;
			end
			OP_HANDSHAKE: begin
				upd_we = known;
				upd_flush = known && (rd_word.slot_epoch != epoch_q);
				upd_word.state = ST_ONLINE;
				upd_word.heartbeat_time = time_q;
				upd_word.slot_epoch = epoch_q;
			end
			OP_HEARTBEAT: begin
				upd_we = known;
				if (rd_word.state == ST_SUSPECT || rd_word.state == ST_OFFLINE) begin
					upd_word.state = ST_ONLINE;
				end
				upd_word.heartbeat_time = time_q;
			end
			OP_DOWN: begin
				upd_we = known;
				upd_flush = known;
				upd_word.state = ST_OFFLINE;
			end
			OP_ROUTES: begin
				upd_accept = known && (rd_word.slot_epoch == epoch_q);
			end
			default: begin
				upd_we = 1'b0;
			end
		endcase
	end

	assign ram_we = sweep_we || (cmd.update && upd_we);
	assign ram_waddr = cmd.sweep ? proc_idx_s1 : slot_addr;
	assign ram_wdata = cmd.sweep ? WORD_W'(sweep_word) : WORD_W'(upd_word);
	assign ram_raddr = cmd.sweep ? rd_cnt_q[ADDR_W-1:0] : slot_addr;

	hlt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NODE_SLOTS)
	) u_slot_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		result.node_known = known;
		result.node_state_out = known ? rd_word.state : '0;
		result.reach_status = reach_of(known, rd_word.state);
		result.change_count = change_q;
		result.routes_flush = flush_q;
		result.routes_accepted = accepted_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= req_data.operation;
			slot_q <= req_data.node_slot;
			epoch_q <= req_data.peer_epoch;
			time_q <= req_data.time_now;
		end
		if (cmd.report) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suspect_q <= SUSPECT_RESET;
			offline_q <= OFFLINE_RESET;
			running_q <= 1'b0;
			valid_q <= '0;
			rd_cnt_q <= '0;
			proc_s1 <= 1'b0;
			proc_idx_s1 <= '0;
			change_q <= '0;
			flush_q <= 1'b0;
			accepted_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SUSPECT: suspect_q <= cfg_data;
					CFG_OFFLINE: offline_q <= cfg_data;
					default: suspect_q <= suspect_q;
				endcase
			end
			if (cmd.latch) begin
				rd_cnt_q <= '0;
				proc_s1 <= 1'b0;
				change_q <= '0;
				flush_q <= 1'b0;
				accepted_q <= 1'b0;
			end
			if (cmd.sweep) begin
				if (op_q == OP_STOP) begin
					running_q <= 1'b0;
				end
				if (sweep_active) begin
					proc_s1 <= 1'b1;
					proc_idx_s1 <= rd_cnt_q[ADDR_W-1:0];
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end else begin
					proc_s1 <= 1'b0;
				end
				if (proc_s1 && tick_change) begin
					change_q <= change_q + 5'd1;
				end
			end
			if (cmd.update) begin
				if (upd_start) begin
					running_q <= 1'b1;
				end
				if (op_q == OP_ADD && in_table) begin
					valid_q[slot_addr] <= 1'b1;
				end
				flush_q <= upd_flush;
				accepted_q <= upd_accept;
			end
			if (cmd.report) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.sweep_req = running_q
		&& (req_data.operation == OP_TICK || req_data.operation == OP_STOP);
	assign status.sweep_done = !sweep_active && !proc_s1;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
endmodule

// ===== hw/rtl/heartbeat_liveness_tracker_unit.sv =====
// Heartbeat failure detector over NODE_SLOTS peer slots. The block takes one request word at a
// time and returns exactly one result word for it. An add, start, query, handshake, heartbeat,
// peer down or routes check goes through the read, update, fetch and report states to the
// result register. A tick or a stop while running sweeps every slot through the slot memory,
// one slot per cycle. The next request is accepted while a finished result still waits in the
// output register. Slot valid bits are cleared at reset, so there is no clearing pass. The
// user must write timeout registers through the cfg port while idle; the block does not check.
module heartbeat_liveness_tracker_unit #(
	parameter int NODE_SLOTS = hlt_pkg::HLT_NODE_SLOTS
) (
	input logic clk,
	input logic arst_n,
	hlt_stream_if.sink request,
	hlt_stream_if.source response,
	input logic cfg_we,
	input logic [hlt_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hlt_pkg::CFG_W-1:0] cfg_data
);
	import hlt_pkg::*;

	ctl_cmd_t cmd;
	dp_status_t status;
	logic in_ready;
	logic out_valid;
	result_t out_data;

	hlt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(request.valid),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	hlt_dp #(
		.NODE_SLOTS(NODE_SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_data(request.data),
		.cmd(cmd),
		.status(status),
		.out_valid(out_valid),
		.out_data(out_data),
		.out_ready(response.ready)
	);

	assign request.ready = in_ready;
	assign response.valid = out_valid;
	assign response.data = out_data;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !request.ready)
		else $error("A second word was accepted while one is in work.");

	a_result_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(response.valid) |-> $past(cmd.report))
		else $error("A result appeared without a report command.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> (!response.valid || response.ready))
		else $error("A waiting result was overwritten.");

	a_exclusive_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep && cmd.update))
		else $error("Sweep and single-slot update were issued together.");
endmodule
